@@ rtl/kic_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator package
// Key codes, event kinds, controller states and the request bundle that
// the controller hands to the iterative arithmetic unit.
// ----------------------------------------------------------------------------
package kic_pkg;

  // Default datapath width of the calculator.
  localparam int unsigned WORD_BITS_DEF = 32;

  // Width of a key code and of the reported result.
  localparam int unsigned KEY_BITS = 5;
  localparam int unsigned OUT_BITS = 32;

  // Key codes. Codes below KEY_DIV are digits whose value is the code.
  localparam logic [KEY_BITS-1:0] KEY_DIV = 5'd24;
  localparam logic [KEY_BITS-1:0] KEY_MUL = 5'd25;
  localparam logic [KEY_BITS-1:0] KEY_SUB = 5'd26;
  localparam logic [KEY_BITS-1:0] KEY_EQ  = 5'd27;
  localparam logic [KEY_BITS-1:0] KEY_ADD = 5'd28;
  localparam logic [KEY_BITS-1:0] KEY_CLR = 5'd29;

  // Digit weight when a key extends the number being typed.
  localparam int unsigned DIGIT_RADIX = 10;

  // Kind of event reported with each result beat.
  typedef enum logic [2:0] {
    EV_DIGIT   = 3'd0,
    EV_OPER    = 3'd1,
    EV_RESULT  = 3'd2,
    EV_CLEARED = 3'd3,
    EV_NONE    = 3'd4,
    EV_DIVZERO = 3'd5
  } evt_kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Request to the arithmetic unit.
  typedef struct packed {
    logic start;   // load operands and begin iterating
    logic op_div;  // restoring division instead of shift-and-add
    logic cin;     // carry into the first shift-and-add step
  } alu_req_t;

endpackage

@@ rtl/kic_alu.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator iterative arithmetic unit
// Runs WORD_BITS steps of either shift-and-add (p + a*b + cin) or
// restoring division (p / a), one multiplier bit or quotient bit per cycle.
// ----------------------------------------------------------------------------
module kic_alu #(
  parameter int unsigned WORD_BITS = kic_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kic_pkg::alu_req_t    req_i,
  input  logic [WORD_BITS-1:0] a_i,    // addend or divisor
  input  logic [WORD_BITS-1:0] b_i,    // multiplier bits
  input  logic [WORD_BITS-1:0] p_i,    // initial sum or dividend
  output logic                 done_o,
  output logic [WORD_BITS-1:0] res_o
);
  import kic_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 div_q, div_d;
  logic                 cin_q, cin_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] b_q, b_d;
  logic [WORD_BITS-1:0] p_q, p_d;
  logic [WORD_BITS:0]   rem_q, rem_d;

  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS-1:0] mac_sum;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   rem_diff;

  // One step of each algorithm.
  assign addend   = b_q[0] ? a_q : '0;
  assign mac_sum  = p_q + addend + WORD_BITS'(cin_q);
  assign rem_sh   = {rem_q[WORD_BITS-1:0], p_q[WORD_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, a_q};

  // Iteration control and operand shifting.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    cin_d  = cin_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.op_div;
      cin_d  = req_i.cin;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      p_d    = p_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (div_q) begin
        // Dividend shifts out at the top, quotient bits enter at the bottom.
        if (!rem_diff[WORD_BITS]) begin
          rem_d = rem_diff;
          p_d   = {p_q[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          p_d   = {p_q[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        p_d   = mac_sum;
        a_d   = {a_q[WORD_BITS-2:0], 1'b0};
        b_d   = {1'b0, b_q[WORD_BITS-1:1]};
        cin_d = 1'b0;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    cin_q <= cin_d;
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    p_q   <= p_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = p_q;

endmodule

@@ rtl/keypad_integer_calculator_top.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator
// Unsigned two-operand four-function calculator driven by one key per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one key code and produces exactly one output beat
// with an event kind and a value. Clear, operator and invalid keys and a
// division by zero are answered without the iterative unit. Digit keys and
// equals with a pending operation go through a shared iterative unit that
// takes one step per cycle for WORD_BITS steps (shift-and-add for the digit
// update, sum, difference and product; restoring division for the
// quotient). Keys are taken only in idle, once the result is loaded, while
// the registered output stage, which holds each beat until taken, is free.
module keypad_integer_calculator_top #(
  parameter int unsigned WORD_BITS = kic_pkg::WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] key_code, [7:5] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);
  import kic_pkg::*;

  state_e               state_q, state_d;
  logic                 phase_q, phase_d;
  logic                 digit_q, digit_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS-1:0] first_q, first_d;
  logic [KEY_BITS-1:0]  pend_q, pend_d;

  logic                 out_valid_q, out_valid_d;
  evt_kind_e            out_kind_q, out_kind_d;
  logic [OUT_BITS-1:0]  out_val_q, out_val_d;

  logic                 out_free;
  logic                 out_load;
  logic                 s_fire;
  logic                 do_restart;
  logic [KEY_BITS-1:0]  key;

  alu_req_t             alu_req;
  logic [WORD_BITS-1:0] alu_a, alu_b, alu_p;
  logic                 alu_done;
  logic [WORD_BITS-1:0] alu_res;

  assign key      = s_axis_tdata[KEY_BITS-1:0];
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (alu_req.start) state_d = ST_RUN;
      ST_RUN:    if (alu_done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Key decoding, operand selection and result formation.
  always_comb begin
    phase_d    = phase_q;
    digit_d    = digit_q;
    acc_d      = acc_q;
    first_d    = first_q;
    pend_d     = pend_q;
    do_restart = 1'b0;
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_val_d  = out_val_q;
    alu_req    = '0;
    alu_a      = '0;
    alu_b      = '0;
    alu_p      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (key < KEY_DIV) begin
            // Digit: acc * 10 + key through the shift-and-add unit.
            alu_req.start = 1'b1;
            alu_a   = acc_q;
            alu_b   = WORD_BITS'(DIGIT_RADIX);
            alu_p   = WORD_BITS'(key);
            digit_d = 1'b1;
          end else if (key == KEY_CLR) begin
            do_restart = 1'b1;
            out_load   = 1'b1;
            out_kind_d = EV_CLEARED;
            out_val_d  = '1;
          end else if (!phase_q) begin
            if (key == KEY_DIV || key == KEY_MUL || key == KEY_SUB ||
                key == KEY_ADD) begin
              first_d    = acc_q;
              pend_d     = key;
              acc_d      = '0;
              phase_d    = 1'b1;
              out_load   = 1'b1;
              out_kind_d = EV_OPER;
              out_val_d  = '0;
            end else begin
              do_restart = 1'b1;
              out_load   = 1'b1;
              out_kind_d = EV_NONE;
              out_val_d  = '1;
            end
          end else if (key != KEY_EQ) begin
            do_restart = 1'b1;
            out_load   = 1'b1;
            out_kind_d = EV_NONE;
            out_val_d  = '1;
          end else begin
            // Equals in the second phase: run the pending operation.
            digit_d = 1'b0;
            case (pend_q)
              KEY_ADD: begin
                alu_req.start = 1'b1;
                alu_p = first_q;
                alu_a = acc_q;
                alu_b = WORD_BITS'(1);
              end
              KEY_SUB: begin
                // first + ~acc + 1
                alu_req.start = 1'b1;
                alu_req.cin   = 1'b1;
                alu_p = first_q;
                alu_a = ~acc_q;
                alu_b = WORD_BITS'(1);
              end
              KEY_MUL: begin
                alu_req.start = 1'b1;
                alu_p = '0;
                alu_a = first_q;
                alu_b = acc_q;
              end
              KEY_DIV: begin
                if (acc_q == '0) begin
                  do_restart = 1'b1;
                  out_load   = 1'b1;
                  out_kind_d = EV_DIVZERO;
                  out_val_d  = '1;
                end else begin
                  alu_req.start  = 1'b1;
                  alu_req.op_div = 1'b1;
                  alu_p = first_q;
                  alu_a = acc_q;
                end
              end
              default: begin
                do_restart = 1'b1;
                out_load   = 1'b1;
                out_kind_d = EV_NONE;
                out_val_d  = '1;
              end
            endcase
          end
        end
      end
      ST_RUN: begin
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (digit_q) begin
            acc_d      = alu_res;
            out_kind_d = EV_DIGIT;
            out_val_d  = '0;
          end else begin
            do_restart = 1'b1;
            out_kind_d = EV_RESULT;
            out_val_d  = OUT_BITS'(alu_res);
          end
        end
      end
      default: begin
      end
    endcase

    if (do_restart) begin
      phase_d = 1'b0;
      acc_d   = '0;
      first_d = '0;
      pend_d  = '0;
    end
  end

  // Output stage handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and calculator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      digit_q     <= 1'b0;
      acc_q       <= '0;
      first_q     <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      digit_q     <= digit_d;
      acc_q       <= acc_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_val_q  <= out_val_d;
  end

  kic_alu #(
    .WORD_BITS(WORD_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .p_i   (alu_p),
    .done_o(alu_done),
    .res_o (alu_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

@@ rtl/kic_checker.sv @@
// ----------------------------------------------------------------------------
// Keypad integer calculator port checker
// Watches the top-level ports for handshake and result-coding slips.
// ----------------------------------------------------------------------------
module kic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import kic_pkg::*;

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("result beat dropped or changed while stalled");

  // Error and clear kinds always carry an all-ones value.
  a_ones_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_CLEARED || m_axis_tuser == EV_NONE ||
                      m_axis_tuser == EV_DIVZERO) |-> m_axis_tdata == '1)
    else $error("clear or error beat without all-ones value");

  // Digit and operator beats carry a zero value.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_DIGIT || m_axis_tuser == EV_OPER)
    |-> m_axis_tdata == '0)
    else $error("digit or operator beat with nonzero value");

  // A clear key is answered in the next cycle.
  a_clear_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[KEY_BITS-1:0] == KEY_CLR
    |=> m_axis_tvalid && m_axis_tuser == EV_CLEARED)
    else $error("clear key not answered in the next cycle");

endmodule

bind keypad_integer_calculator_top kic_checker u_kic_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
